// ===== hdl/sonar_sweep_display_controller_assert.svh =====
// Assertion macros used by the top level of the sonar sweep display controller.
`ifndef SONAR_SWEEP_DISPLAY_CONTROLLER_ASSERT_SVH
`define SONAR_SWEEP_DISPLAY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSDC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssdc_pkg.sv =====
// Package with the types, constants and helper functions of the sonar sweep display controller.
`default_nettype none

package ssdc_pkg;

    localparam int TICK_W  = 22;
    localparam int ANGLE_W = 8;
    localparam int CMP_W   = 10;
    localparam int DIST_W  = 16;
    localparam int SHOWN_W = 14;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 8;
    localparam int FRAME_W = 2;
    localparam int Q1_W    = 21;
    localparam int CY_W    = 13;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ANGLE_W-1:0] TOP_ANGLE  = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP = 8'd2;
    localparam logic [CMP_W-1:0]   CMP_BASE   = 10'd105;
    localparam logic [6:0]         CMP_MUL    = 7'd101;
    localparam logic [CY_W-1:0]    CMP_RECIP  = 13'd7282;
    localparam logic [21:0]        DIST_RECIP = 22'd2314098;
    localparam logic [4:0]         DIST_DIV   = 5'd29;
    localparam logic [DIST_W-1:0]  DIST_MAX   = 16'd45197;
    localparam logic [SHOWN_W-1:0] DISPLAY_MAX = 14'd9999;
    localparam logic [FRAME_W-1:0] FIRST_FRAME = 2'd0;
    localparam logic [FRAME_W-1:0] LAST_FRAME  = 2'd3;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [CMP_W-1:0]   cmp;
        logic [DIST_W-1:0]  distance;
        logic [SHOWN_W-1:0] shown;
    } ssdc_entry_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

    function automatic logic [SEL_W-1:0] sel_of(input logic [FRAME_W-1:0] frame);
        logic [SEL_W-1:0] sel;
        case (frame)
            2'd0:    sel = 8'hF8;
            2'd1:    sel = 8'hF4;
            2'd2:    sel = 8'hF2;
            default: sel = 8'hF1;
        endcase
        return sel;
    endfunction

    function automatic logic [SHOWN_W-1:0] divisor_of(input logic [FRAME_W-1:0] frame);
        logic [SHOWN_W-1:0] div;
        case (frame)
            2'd0:    div = 14'd1000;
            2'd1:    div = 14'd100;
            2'd2:    div = 14'd10;
            default: div = 14'd1;
        endcase
        return div;
    endfunction

    // Decimal digit of a value below ten times the divisor, by parallel compares.
    function automatic logic [3:0] digit_of(input logic [SHOWN_W-1:0] value,
                                            input logic [SHOWN_W-1:0] div);
        logic [3:0] digit;
        digit = 4'd0;
        for (int j = 1; j < 10; j++) begin
            if (32'(value) >= j * 32'(div)) begin
                digit = digit + 4'd1;
            end
        end
        return digit;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ssdc_front.sv =====
// Front part: accepts echo widths, tracks the sweep and converts widths to distances.
`default_nettype none

module ssdc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ssdc_pkg::TICK_W-1:0]     echo_ticks,
    input  wire logic                            echo_valid,
    output logic                                 echo_ready,
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output ssdc_pkg::ssdc_entry_t                push_entry
);

    logic                           advance;
    logic                           accept;

    logic [ssdc_pkg::ANGLE_W-1:0]   angle_reg, angle_next;
    logic                           down_reg, down_next;
    logic [ssdc_pkg::DIST_W-1:0]    min_reg, min_next;

    logic                           s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [ssdc_pkg::ANGLE_W-1:0]   s1_angle_reg, s2_angle_reg, s3_angle_reg;
    logic                           s1_down_reg, s2_down_reg, s3_down_reg;
    logic                           s1_start_reg, s2_start_reg, s3_start_reg;
    logic [ssdc_pkg::Q1_W-1:0]      s1_q1_reg, s2_q1_reg;
    logic [ssdc_pkg::CY_W-1:0]      s1_cy_reg;
    logic [ssdc_pkg::CMP_W-1:0]     s2_cmp_reg, s3_cmp_reg;
    logic [ssdc_pkg::DIST_W-1:0]    s2_est_reg, s3_dist_reg;

    logic [24:0]                    ticks_x5;
    logic [14:0]                    angle_x101;
    logic [42:0]                    dist_prod;
    logic [25:0]                    cmp_prod;
    logic [ssdc_pkg::Q1_W-1:0]      est_x29;
    logic [ssdc_pkg::Q1_W-1:0]      rem;
    logic [ssdc_pkg::DIST_W-1:0]    dist_fixed;

    logic [ssdc_pkg::DIST_W-1:0]    min_base;
    logic [ssdc_pkg::DIST_W-1:0]    min_new;
    logic [ssdc_pkg::SHOWN_W-1:0]   shown;

    assign advance    = !s3_valid_reg || push_ready;
    assign echo_ready = advance;
    assign accept     = echo_valid && advance;

    always_comb
    begin
        angle_next = angle_reg;
        down_next  = down_reg;
        if (accept) begin
            if (!down_reg) begin
                if (angle_reg >= ssdc_pkg::TOP_ANGLE) begin
                    down_next = 1'b1;
                end else begin
                    angle_next = angle_reg + ssdc_pkg::ANGLE_STEP;
                end
            end else begin
                if (angle_reg == '0) begin
                    down_next = 1'b0;
                end else if (angle_reg < ssdc_pkg::ANGLE_STEP) begin
                    angle_next = '0;
                end else begin
                    angle_next = angle_reg - ssdc_pkg::ANGLE_STEP;
                end
            end
        end
    end

    assign ticks_x5   = {1'b0, echo_ticks, 2'b00} + {3'b000, echo_ticks};
    assign angle_x101 = {7'd0, angle_reg} * {8'd0, ssdc_pkg::CMP_MUL};

    assign dist_prod  = {22'd0, s1_q1_reg} * {21'd0, ssdc_pkg::DIST_RECIP};
    assign cmp_prod   = {13'd0, s1_cy_reg} * {13'd0, ssdc_pkg::CMP_RECIP};

    assign est_x29    = 21'({5'd0, s2_est_reg} * {16'd0, ssdc_pkg::DIST_DIV});
    assign rem        = s2_q1_reg - est_x29;
    assign dist_fixed = (rem >= {16'd0, ssdc_pkg::DIST_DIV}) ? s2_est_reg + 16'd1 : s2_est_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            angle_reg    <= '0;
            down_reg     <= 1'b0;
            min_reg      <= {2'b00, ssdc_pkg::DISPLAY_MAX};
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            angle_reg <= angle_next;
            down_reg  <= down_next;
            min_reg   <= min_next;
            if (advance) begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_angle_reg <= angle_reg;
            s1_down_reg  <= down_reg;
            s1_start_reg <= !down_reg && (angle_reg == '0);
            s1_q1_reg    <= ticks_x5[24:4];
            s1_cy_reg    <= angle_x101[14:2];

            s2_angle_reg <= s1_angle_reg;
            s2_down_reg  <= s1_down_reg;
            s2_start_reg <= s1_start_reg;
            s2_q1_reg    <= s1_q1_reg;
            s2_est_reg   <= dist_prod[41:26];
            s2_cmp_reg   <= ssdc_pkg::CMP_BASE + cmp_prod[25:16];

            s3_angle_reg <= s2_angle_reg;
            s3_down_reg  <= s2_down_reg;
            s3_start_reg <= s2_start_reg;
            s3_cmp_reg   <= s2_cmp_reg;
            s3_dist_reg  <= dist_fixed;
        end
    end

    assign min_base = s3_start_reg ? {2'b00, ssdc_pkg::DISPLAY_MAX} : min_reg;
    assign min_new  = (s3_dist_reg < min_base) ? s3_dist_reg : min_base;

    always_comb
    begin
        min_next = min_reg;
        if (s3_down_reg) begin
            if (s3_dist_reg > {2'b00, ssdc_pkg::DISPLAY_MAX}) begin
                shown = ssdc_pkg::DISPLAY_MAX;
            end else begin
                shown = s3_dist_reg[ssdc_pkg::SHOWN_W-1:0];
            end
        end else begin
            shown = min_new[ssdc_pkg::SHOWN_W-1:0];
            if (s3_valid_reg && push_ready) begin
                min_next = min_new;
            end
        end
    end

    assign push_valid          = s3_valid_reg;
    assign push_entry.angle    = s3_angle_reg;
    assign push_entry.cmp      = s3_cmp_reg;
    assign push_entry.distance = s3_dist_reg;
    assign push_entry.shown    = shown;

endmodule

`default_nettype wire

// ===== hdl/ssdc_queue.sv =====
// Short queue of measurement entries between the front and back parts.
`default_nettype none

module ssdc_queue #(
    parameter int DEPTH = ssdc_pkg::QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push_valid,
    output logic                         push_ready,
    input  wire ssdc_pkg::ssdc_entry_t   push_entry,
    output logic                         pop_valid,
    input  wire logic                    pop_ready,
    output ssdc_pkg::ssdc_entry_t        pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ssdc_pkg::ssdc_entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ssdc_back.sv =====
// Back part: splits each entry into four digit frames and drives the frame output register.
`default_nettype none

module ssdc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pop_valid,
    output logic                                 pop_ready,
    input  wire ssdc_pkg::ssdc_entry_t           pop_entry,
    output logic                                 frame_valid,
    input  wire logic                            frame_ready,
    output logic [ssdc_pkg::ANGLE_W-1:0]         sweep_angle_out,
    output logic [ssdc_pkg::CMP_W-1:0]           servo_compare,
    output logic [ssdc_pkg::DIST_W-1:0]          distance_mm,
    output logic [ssdc_pkg::SEG_W-1:0]           segment_pattern,
    output logic [ssdc_pkg::SEL_W-1:0]           digit_enable_mask,
    output logic                                 last_frame
);

    logic                            out_valid_reg, out_valid_next;
    logic [ssdc_pkg::FRAME_W-1:0]    frame_reg, frame_next;
    logic [ssdc_pkg::SHOWN_W-1:0]    rem_reg;
    logic [ssdc_pkg::ANGLE_W-1:0]    angle_reg;
    logic [ssdc_pkg::CMP_W-1:0]      cmp_reg;
    logic [ssdc_pkg::DIST_W-1:0]     dist_reg;
    logic [ssdc_pkg::SEG_W-1:0]      seg_reg;
    logic [ssdc_pkg::SEL_W-1:0]      sel_reg;
    logic                            last_reg;

    logic                            room;
    logic                            load;
    logic [ssdc_pkg::SHOWN_W-1:0]    src;
    logic [ssdc_pkg::SHOWN_W-1:0]    div;
    logic [3:0]                      digit;
    logic [ssdc_pkg::SHOWN_W-1:0]    rem_next;

    assign room      = !out_valid_reg || frame_ready;
    assign load      = pop_valid && room;
    assign pop_ready = room && (frame_reg == ssdc_pkg::LAST_FRAME);

    assign src      = (frame_reg == ssdc_pkg::FIRST_FRAME) ? pop_entry.shown : rem_reg;
    assign div      = ssdc_pkg::divisor_of(frame_reg);
    assign digit    = ssdc_pkg::digit_of(src, div);
    assign rem_next = src - ssdc_pkg::SHOWN_W'(digit * div);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        frame_next     = frame_reg;
        if (load) begin
            out_valid_next = 1'b1;
            frame_next     = frame_reg + ssdc_pkg::FRAME_W'(1);
        end else if (frame_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            frame_reg     <= ssdc_pkg::FIRST_FRAME;
        end else begin
            out_valid_reg <= out_valid_next;
            frame_reg     <= frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            rem_reg   <= rem_next;
            angle_reg <= pop_entry.angle;
            cmp_reg   <= pop_entry.cmp;
            dist_reg  <= pop_entry.distance;
            seg_reg   <= ssdc_pkg::seg_of(digit);
            sel_reg   <= ssdc_pkg::sel_of(frame_reg);
            last_reg  <= (frame_reg == ssdc_pkg::LAST_FRAME);
        end
    end

    assign frame_valid       = out_valid_reg;
    assign sweep_angle_out   = angle_reg;
    assign servo_compare     = cmp_reg;
    assign distance_mm       = dist_reg;
    assign segment_pattern   = seg_reg;
    assign digit_enable_mask = sel_reg;
    assign last_frame        = last_reg;

endmodule

`default_nettype wire

// ===== hdl/sonar_sweep_display_controller.sv =====
// Top level of the sonar sweep display controller.
//
// Each transfer on the echo channel (echo_valid, echo_ready, echo_ticks) is one echo
// pulse width taken at the current servo angle. For each one the block sends four
// transfers on the frame channel (frame_valid, frame_ready and the frame fields),
// thousands digit first, with last_frame set on the ones digit. Every frame carries the
// angle, the servo compare value and the distance of that measurement.
// An echo passes the three front stages, the queue and the frame output register before
// its first frame is valid; the following frames come one per cycle while frame_ready is
// high. The digit splitter in the back part takes a new entry only after all four frames
// of the last one. A three-stage conversion pipeline in the front part and a two-entry
// queue keep taking echoes while the frame output is stalled, until they fill; then
// echo_ready drops.
// Reset sets the angle to 0, the sweep direction to up and the running minimum to 9999,
// and empties the pipeline, the queue and the frame output.
`default_nettype none

module sonar_sweep_display_controller #(
    parameter int QUEUE_DEPTH = ssdc_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ssdc_pkg::TICK_W-1:0]     echo_ticks,
    input  wire logic                            echo_valid,
    output logic                                 echo_ready,
    output logic                                 frame_valid,
    input  wire logic                            frame_ready,
    output logic [ssdc_pkg::ANGLE_W-1:0]         sweep_angle_out,
    output logic [ssdc_pkg::CMP_W-1:0]           servo_compare,
    output logic [ssdc_pkg::DIST_W-1:0]          distance_mm,
    output logic [ssdc_pkg::SEG_W-1:0]           segment_pattern,
    output logic [ssdc_pkg::SEL_W-1:0]           digit_enable_mask,
    output logic                                 last_frame
);

`include "sonar_sweep_display_controller_assert.svh"

    logic                    push_valid;
    logic                    push_ready;
    ssdc_pkg::ssdc_entry_t   push_entry;
    logic                    pop_valid;
    logic                    pop_ready;
    ssdc_pkg::ssdc_entry_t   pop_entry;

    ssdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .echo_ticks (echo_ticks),
        .echo_valid (echo_valid),
        .echo_ready (echo_ready),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    ssdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ssdc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_entry         (pop_entry),
        .frame_valid       (frame_valid),
        .frame_ready       (frame_ready),
        .sweep_angle_out   (sweep_angle_out),
        .servo_compare     (servo_compare),
        .distance_mm       (distance_mm),
        .segment_pattern   (segment_pattern),
        .digit_enable_mask (digit_enable_mask),
        .last_frame        (last_frame)
    );

    `SSDC_ASSERT_IMPL(a_last_select, frame_valid && last_frame,
        digit_enable_mask == ssdc_pkg::sel_of(ssdc_pkg::LAST_FRAME), "last frame has wrong select")
    `SSDC_ASSERT_NEXT(a_frame_burst, frame_valid && frame_ready && !last_frame,
        frame_valid, "gap inside a frame group")
    `SSDC_ASSERT_NEXT(a_pop_on_last, pop_valid && pop_ready,
        frame_valid && last_frame, "queue entry released before its last frame")
    `SSDC_ASSERT_IMPL(a_dist_range, frame_valid,
        distance_mm <= ssdc_pkg::DIST_MAX, "distance out of range")

endmodule

`default_nettype wire

// ===== tb/tb_sonar_sweep_display_controller.sv =====
// Self-checking testbench for the sonar sweep display controller.
`timescale 1ns / 1ps

module tb_sonar_sweep_display_controller;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int REPORT_MAX  = 10;
    localparam int unsigned SHOW_MAX = 9999;

    typedef struct packed {
        logic [ssdc_pkg::ANGLE_W-1:0] angle;
        logic [ssdc_pkg::CMP_W-1:0]   cmp;
        logic [ssdc_pkg::DIST_W-1:0]  distance;
        logic [ssdc_pkg::SEG_W-1:0]   seg;
        logic [ssdc_pkg::SEL_W-1:0]   sel;
        logic                         last;
    } display_frame_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [ssdc_pkg::TICK_W-1:0]      echo_ticks = '0;
    logic                             echo_valid = 1'b0;
    logic                             echo_ready;
    logic                             frame_valid;
    logic                             frame_ready = 1'b0;
    logic [ssdc_pkg::ANGLE_W-1:0]     sweep_angle_out;
    logic [ssdc_pkg::CMP_W-1:0]       servo_compare;
    logic [ssdc_pkg::DIST_W-1:0]      distance_mm;
    logic [ssdc_pkg::SEG_W-1:0]       segment_pattern;
    logic [ssdc_pkg::SEL_W-1:0]       digit_enable_mask;
    logic                             last_frame;

    logic [ssdc_pkg::TICK_W-1:0]      echo_backlog[$];
    display_frame_t                   expected_frames[$];
    display_frame_t                   got_frame;
    display_frame_t                   want_frame;

    logic [ssdc_pkg::ANGLE_W-1:0]     model_angle;
    logic                             model_down;
    logic [ssdc_pkg::DIST_W-1:0]      model_min;

    int                    send_idle_pct = 36;
    int                    recv_idle_pct = 70;
    logic                  hold_req = 1'b0;
    int                    hold_left = 0;
    int                    items_queued = 0;
    int                    items_taken = 0;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;

    sonar_sweep_display_controller u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .echo_ticks        (echo_ticks),
        .echo_valid        (echo_valid),
        .echo_ready        (echo_ready),
        .frame_valid       (frame_valid),
        .frame_ready       (frame_ready),
        .sweep_angle_out   (sweep_angle_out),
        .servo_compare     (servo_compare),
        .distance_mm       (distance_mm),
        .segment_pattern   (segment_pattern),
        .digit_enable_mask (digit_enable_mask),
        .last_frame        (last_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ssdc_pkg::SEG_W-1:0] digit_segments(input int unsigned digit);
        logic [ssdc_pkg::SEG_W-1:0] pattern;
        case (digit)
            0:       pattern = 8'hC0;
            1:       pattern = 8'hF9;
            2:       pattern = 8'hA4;
            3:       pattern = 8'hB0;
            4:       pattern = 8'h99;
            5:       pattern = 8'h92;
            6:       pattern = 8'h82;
            7:       pattern = 8'hF8;
            8:       pattern = 8'h80;
            default: pattern = 8'h90;
        endcase
        return pattern;
    endfunction

    function automatic logic [ssdc_pkg::SEL_W-1:0] digit_enable(input int k);
        logic [ssdc_pkg::SEL_W-1:0] enable;
        case (k)
            0:       enable = 8'hF8;
            1:       enable = 8'hF4;
            2:       enable = 8'hF2;
            default: enable = 8'hF1;
        endcase
        return enable;
    endfunction

    // Advances the sweep by one measurement and queues its four display frames.
    task automatic forecast_frames(input logic [ssdc_pkg::TICK_W-1:0] ticks);
        int unsigned    dist_mm;
        int unsigned    angle;
        int unsigned    cmp;
        int unsigned    shown;
        int unsigned    divisor;
        display_frame_t frame;
        dist_mm = (32'(ticks) * 10) / 928;
        angle   = model_angle;
        cmp     = 105 + (angle * 505) / 180;
        if (!model_down)
        begin
            if (angle == 0)
            begin
                model_min = 16'(SHOW_MAX);
            end
            if (dist_mm < model_min)
            begin
                model_min = 16'(dist_mm);
            end
            shown = model_min;
            if (angle >= 180)
            begin
                model_down = 1'b1;
            end
            else
            begin
                model_angle = 8'(angle + 2);
            end
        end
        else
        begin
            shown = (dist_mm > SHOW_MAX) ? SHOW_MAX : dist_mm;
            if (angle == 0)
            begin
                model_down = 1'b0;
            end
            else if (angle < 2)
            begin
                model_angle = '0;
            end
            else
            begin
                model_angle = 8'(angle - 2);
            end
        end
        if (shown > SHOW_MAX)
        begin
            shown = SHOW_MAX;
        end
        divisor = 1000;
        for (int k = 0; k < 4; k++)
        begin
            frame.angle    = 8'(angle);
            frame.cmp      = 10'(cmp);
            frame.distance = 16'(dist_mm);
            frame.seg      = digit_segments((shown / divisor) % 10);
            frame.sel      = digit_enable(k);
            frame.last     = (k == 3);
            expected_frames.push_back(frame);
            divisor = divisor / 10;
        end
    endtask

    function automatic logic [ssdc_pkg::TICK_W-1:0] random_ticks();
        logic [ssdc_pkg::TICK_W-1:0] ticks;
        case ($urandom_range(0, 3))
            0:       ticks = ssdc_pkg::TICK_W'($urandom);
            1:       ticks = ssdc_pkg::TICK_W'($urandom_range(0, 1113600));
            2:       ticks = ssdc_pkg::TICK_W'($urandom_range(927000, 929000));
            default: ticks = ssdc_pkg::TICK_W'($urandom_range(0, 2000));
        endcase
        return ticks;
    endfunction

    task automatic queue_echo(input logic [ssdc_pkg::TICK_W-1:0] ticks);
        echo_backlog.push_back(ticks);
        items_queued++;
    endtask

    task automatic wait_all_done();
        while (echo_backlog.size() != 0 || items_taken != items_queued ||
               expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_valid  <= 1'b0;
            echo_ticks  <= '0;
            model_angle <= '0;
            model_down  <= 1'b0;
            model_min   <= 16'(SHOW_MAX);
        end
        else
        begin
            if (echo_valid && echo_ready)
            begin
                forecast_frames(echo_ticks);
                items_taken++;
            end
            if (!echo_valid || echo_ready)
            begin
                if (echo_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    echo_ticks <= echo_backlog.pop_front();
                    echo_valid <= 1'b1;
                end
                else
                begin
                    echo_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ready <= 1'b0;
        end
        else
        begin
            if (frame_valid && frame_ready)
            begin
                got_frame = '{sweep_angle_out, servo_compare, distance_mm,
                              segment_pattern, digit_enable_mask, last_frame};
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display({"Unexpected frame: angle %0d cmp %0d dist %0d ",
                                  "seg %h sel %h last %b"},
                                 got_frame.angle, got_frame.cmp, got_frame.distance,
                                 got_frame.seg, got_frame.sel, got_frame.last);
                    end
                end
                else
                begin
                    want_frame = expected_frames.pop_front();
                    if (got_frame !== want_frame)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("Frame mismatch at cycle %0d:", cycle_count);
                            $display({"  expected angle %0d cmp %0d dist %0d ",
                                      "seg %h sel %h last %b"},
                                     want_frame.angle, want_frame.cmp, want_frame.distance,
                                     want_frame.seg, want_frame.sel, want_frame.last);
                            $display({"  actual   angle %0d cmp %0d dist %0d ",
                                      "seg %h sel %h last %b"},
                                     got_frame.angle, got_frame.cmp, got_frame.distance,
                                     got_frame.seg, got_frame.sel, got_frame.last);
                        end
                    end
                end
            end
            frame_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes and the values around the display saturation point.
        queue_echo(ssdc_pkg::TICK_W'(0));
        queue_echo(ssdc_pkg::TICK_W'(22'h3FFFFF));
        queue_echo(ssdc_pkg::TICK_W'(927907));
        queue_echo(ssdc_pkg::TICK_W'(927908));
        queue_echo(ssdc_pkg::TICK_W'(928000));
        queue_echo(ssdc_pkg::TICK_W'(92));
        queue_echo(ssdc_pkg::TICK_W'(928));
        queue_echo(ssdc_pkg::TICK_W'(22'h2AAAAA));
        queue_echo(ssdc_pkg::TICK_W'(22'h155555));
        queue_echo(ssdc_pkg::TICK_W'(1));
        repeat (70) queue_echo(random_ticks());
        wait_all_done();

        send_idle_pct <= 70;
        recv_idle_pct <= 36;
        repeat (70) queue_echo(random_ticks());
        wait_all_done();

        // The receiver stalls for a long stretch while the sender keeps offering echoes.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        repeat (40) queue_echo(random_ticks());
        hold_req <= 1'b1;
        @(posedge clk);
        while (hold_left == 0)
        begin
            @(posedge clk);
        end
        hold_req <= 1'b0;
        wait_all_done();

        repeat (30) queue_echo(random_ticks());
        wait_all_done();
        repeat (12) @(posedge clk);

        if (mismatch_count == 0 && expected_frames.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
